### rtl/brb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brb_pkg
// Shared widths, codes and controller/datapath interface types of the byte
// ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

    localparam int OP_W   = 3;
    localparam int LEN_W  = 4;
    localparam int DATA_W = 64;
    localparam int IDX_W  = 8;
    localparam int ST_W   = 2;
    localparam int CAP_W  = 9;
    // Element-at start address before the modulo: read pointer plus
    // length times index, which stays below 4096.
    localparam int DIV_W  = 12;

    localparam logic [OP_W-1:0] OP_PUSH     = 3'd0;
    localparam logic [OP_W-1:0] OP_PEEK     = 3'd1;
    localparam logic [OP_W-1:0] OP_POP      = 3'd2;
    localparam logic [OP_W-1:0] OP_PEEK_POP = 3'd3;
    localparam logic [OP_W-1:0] OP_ELEM_AT  = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR    = 3'd5;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [ST_W-1:0] ST_TOO_SMALL = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clr_step;
        logic wr_step;
        logic mod_step;
        logic rd_issue;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic plan_write;
        logic plan_read;
        logic plan_mod;
        logic len_last;
        logic mod_last;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

### rtl/brb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brb_ctrl
// Sequencer of the byte ring buffer: clearing pass, per-byte write and read
// loops, the element-at modulo and the hand-off to the output register.
// ----------------------------------------------------------------------------
module brb_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire brb_pkg::t_sts i_sts,
    output brb_pkg::t_cmd      o_cmd
);
    import brb_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_WRITE  = 3'd2;
    localparam logic [2:0] S_MOD    = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;
    localparam logic [2:0] S_DRAIN  = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.plan_write) begin
                        n_state = S_WRITE;
                    end else if (i_sts.plan_mod) begin
                        n_state = S_MOD;
                    end else if (i_sts.plan_read) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_WRITE: begin
                o_cmd.wr_step = 1'b1;
                if (i_sts.len_last) begin
                    n_state = S_FINISH;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_last) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                if (i_sts.len_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/brb_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brb_dp
// Datapath of the byte ring buffer: byte store, pointers, fill count,
// remainder unit for element-at and the output register.
// ----------------------------------------------------------------------------
module brb_dp #(
    parameter int STORE_BYTES  = 256,
    parameter int MAX_TRANSFER = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [brb_pkg::CAP_W-1:0]     i_cap,
    input  wire logic                          i_cfg_clear,
    input  wire brb_pkg::t_cmd                 i_cmd,
    output brb_pkg::t_sts                      o_sts,
    input  wire logic [brb_pkg::OP_W-1:0]      i_opcode,
    input  wire logic [brb_pkg::LEN_W-1:0]     i_length,
    input  wire logic [brb_pkg::DATA_W-1:0]    i_write_data,
    input  wire logic [brb_pkg::IDX_W-1:0]     i_element_index,
    input  wire logic                          i_out_stall,
    output logic                               o_out_valid,
    output logic [brb_pkg::ST_W-1:0]           o_status,
    output logic [brb_pkg::DATA_W-1:0]         o_read_data,
    output logic [brb_pkg::CAP_W-1:0]          o_fill_level
);
    import brb_pkg::*;

    localparam int AW      = $clog2(STORE_BYTES);
    localparam int CAP_MAX = (STORE_BYTES < 511) ? STORE_BYTES : 511;
    localparam int PTR_W   = $clog2(CAP_MAX);
    localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_TRANSFER);
    localparam logic [AW-1:0]    CLR_LAST = AW'(STORE_BYTES - 1);
    localparam logic [LEN_W-1:0] MOD_LAST = LEN_W'(DIV_W - 1);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p,
                                                 input logic [CAP_W-1:0] c);
        logic [CAP_W-1:0] s;
        s = CAP_W'(p) + CAP_W'(1);
        return (s == c) ? '0 : PTR_W'(s);
    endfunction

    logic [7:0]        mem [STORE_BYTES];
    logic [7:0]        r_mem_q;

    logic [PTR_W-1:0]  r_rp;
    logic [PTR_W-1:0]  r_wp;
    logic [CAP_W-1:0]  r_count;
    logic [AW-1:0]     r_clr_addr;
    logic              r_rd_pend;
    logic              r_out_valid;

    logic [PTR_W-1:0]  r_addr;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_cnt;
    logic [2:0]        r_pos;
    logic [DATA_W-1:0] r_wdata;
    logic [DATA_W-1:0] r_rdata;
    logic [ST_W-1:0]   r_status;
    logic [DIV_W-1:0]  r_div;
    logic [CAP_W-1:0]  r_rem;

    logic [LEN_W-1:0]  len_c;
    logic              len_nz;
    logic              fits;
    logic              short_data;
    logic [CAP_W:0]    pop_sum;
    logic [PTR_W-1:0]  rp_pop;
    logic [CAP_W:0]    rem_try;
    logic [CAP_W-1:0]  rem_next;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [7:0]        mem_wbyte;

    // Request decode, evaluated on the item being offered, and the status
    // flags for the controller.
    always_comb begin
        len_c      = (i_length > LEN_MAX) ? LEN_MAX : i_length;
        len_nz     = (len_c != '0);
        fits       = ({1'b0, r_count} + (CAP_W + 1)'(len_c)) <= {1'b0, i_cap};
        short_data = (CAP_W'(len_c) > r_count);
        pop_sum    = (CAP_W + 1)'(r_rp) + (CAP_W + 1)'(len_c);
        rp_pop     = (pop_sum >= {1'b0, i_cap}) ? PTR_W'(pop_sum - {1'b0, i_cap})
                                                : PTR_W'(pop_sum);
        o_sts.plan_write = (i_opcode == OP_PUSH) && len_nz && fits;
        o_sts.plan_read  = ((i_opcode == OP_PEEK) || (i_opcode == OP_PEEK_POP)) &&
                           len_nz && !short_data;
        o_sts.plan_mod   = (i_opcode == OP_ELEM_AT) && len_nz && !short_data;
        o_sts.clr_last   = (r_clr_addr == CLR_LAST);
        o_sts.len_last   = (r_cnt == (r_len - LEN_W'(1)));
        o_sts.mod_last   = (r_cnt == MOD_LAST);
        o_sts.out_free   = !r_out_valid || !i_out_stall;
    end

    // One restoring step of the remainder by the capacity.
    always_comb begin
        rem_try  = {r_rem, r_div[DIV_W-1]};
        rem_next = (rem_try >= {1'b0, i_cap}) ? CAP_W'(rem_try - {1'b0, i_cap})
                                              : CAP_W'(rem_try);
    end

    // Byte store: one write port, one registered read port.
    always_comb begin
        mem_we    = i_cmd.clr_step || i_cmd.wr_step;
        mem_waddr = i_cmd.clr_step ? r_clr_addr : AW'(r_wp);
        mem_wbyte = i_cmd.clr_step ? 8'd0 : r_wdata[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wbyte;
        end
        r_mem_q <= mem[AW'(r_addr)];
    end

    // Buffer state and control flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp        <= '0;
            r_wp        <= '0;
            r_count     <= '0;
            r_clr_addr  <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.rd_issue;
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cfg_clear) begin
                r_rp    <= '0;
                r_wp    <= '0;
                r_count <= '0;
            end else if (i_cmd.load) begin
                case (i_opcode)
                    OP_PUSH: begin
                        if (len_nz && fits) begin
                            r_count <= r_count + CAP_W'(len_c);
                        end
                    end
                    OP_POP, OP_PEEK_POP: begin
                        if (len_nz && !short_data) begin
                            r_rp    <= rp_pop;
                            r_count <= r_count - CAP_W'(len_c);
                        end
                    end
                    OP_CLEAR: begin
                        r_rp    <= r_wp;
                        r_count <= '0;
                    end
                    default: begin
                    end
                endcase
            end else if (i_cmd.wr_step) begin
                r_wp <= ptr_inc(r_wp, i_cap);
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Per-item working registers and the output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_len   <= len_c;
            r_cnt   <= '0;
            r_pos   <= '0;
            r_wdata <= i_write_data;
            r_rdata <= '0;
            r_addr  <= r_rp;
            r_rem   <= '0;
            r_div   <= DIV_W'(r_rp) + DIV_W'(len_c) * DIV_W'(i_element_index);
            if ((i_opcode == OP_PUSH) && len_nz && !fits) begin
                r_status <= ST_OVERFLOW;
            end else if ((i_opcode != OP_PUSH) && (i_opcode != OP_CLEAR) &&
                         (i_opcode <= OP_ELEM_AT) && len_nz && short_data) begin
                r_status <= ST_TOO_SMALL;
            end else begin
                r_status <= ST_OK;
            end
        end else begin
            if (i_cmd.wr_step) begin
                r_wdata <= r_wdata >> 8;
                r_cnt   <= r_cnt + LEN_W'(1);
            end
            if (i_cmd.mod_step) begin
                r_rem <= rem_next;
                r_div <= r_div << 1;
                if (o_sts.mod_last) begin
                    r_cnt  <= '0;
                    r_addr <= PTR_W'(rem_next);
                end else begin
                    r_cnt <= r_cnt + LEN_W'(1);
                end
            end
            if (i_cmd.rd_issue) begin
                r_addr <= ptr_inc(r_addr, i_cap);
                r_cnt  <= r_cnt + LEN_W'(1);
            end
            if (r_rd_pend) begin
                r_rdata[{r_pos, 3'b000} +: 8] <= r_mem_q;
                r_pos                         <= r_pos + 3'd1;
            end
        end
        if (i_cmd.finish) begin
            o_status     <= r_status;
            o_read_data  <= r_rdata;
            o_fill_level <= r_count;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

### rtl/byte_ring_buffer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_buffer
// Circular byte buffer over a byte-wide store with push, peek, pop,
// peek-and-pop, element-at and clear requests of up to eight bytes.
// ----------------------------------------------------------------------------
// Clear, pop, failures and zero lengths go straight to the result stage;
// push writes its bytes one by one; peek and peek-and-pop read theirs one
// by one; element-at reads after its 12-step remainder unit runs first.
// One item is in flight at a time: o_stall stays high until its result is loaded.
// After reset the store is swept to zero, with o_stall high.
// ----------------------------------------------------------------------------
module byte_ring_buffer #(
    parameter int STORE_BYTES  = 256,
    parameter int MAX_TRANSFER = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Request channel.
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [brb_pkg::OP_W-1:0]      i_opcode,
    input  wire logic [brb_pkg::LEN_W-1:0]     i_length,
    input  wire logic [brb_pkg::DATA_W-1:0]    i_write_data,
    input  wire logic [brb_pkg::IDX_W-1:0]     i_element_index,
    // Result channel.
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [brb_pkg::ST_W-1:0]           o_status,
    output logic [brb_pkg::DATA_W-1:0]         o_read_data,
    output logic [brb_pkg::CAP_W-1:0]          o_fill_level,
    // Configuration port.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import brb_pkg::*;

    // Largest usable capacity: bounded by the store and by the 9-bit register.
    localparam int CAP_MAX = (STORE_BYTES < 511) ? STORE_BYTES : 511;
    localparam int CAP_RST = (STORE_BYTES < 256) ? STORE_BYTES : 256;
    localparam logic [CAP_W-1:0] CAP_MAX_V = CAP_W'(CAP_MAX);
    localparam logic [CAP_W-1:0] CAP_RST_V = CAP_W'(CAP_RST);

    // The capacity register keeps the value as written so that reads return
    // it unchanged. A second register holds the clamped capacity that the
    // datapath actually wraps at: zero acts as one, and anything above CAP_MAX
    // acts as CAP_MAX, the store size capped at 511.
    logic [CAP_W-1:0] r_capacity;
    logic [CAP_W-1:0] r_cap_eff;
    logic [CAP_W-1:0] wr_cap;
    logic [CAP_W-1:0] wr_cap_eff;
    logic             cfg_wr;
    logic             cap_sel;

    t_cmd cmd;
    t_sts sts;

    assign pready  = 1'b1;
    assign cap_sel = (paddr[2] == 1'b0);
    assign cfg_wr  = psel && penable && pwrite && cap_sel;
    assign wr_cap  = pwdata[CAP_W-1:0];

    always_comb begin
        if (wr_cap == '0) begin
            wr_cap_eff = CAP_W'(1);
        end else if (wr_cap > CAP_MAX_V) begin
            wr_cap_eff = CAP_MAX_V;
        end else begin
            wr_cap_eff = wr_cap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_W'(256);
            r_cap_eff  <= CAP_RST_V;
        end else if (cfg_wr) begin
            r_capacity <= wr_cap;
            r_cap_eff  <= wr_cap_eff;
        end
    end

    assign prdata = cap_sel ? {{(32 - CAP_W){1'b0}}, r_capacity} : 32'd0;

    // The controller sequences each item; the datapath owns the store,
    // pointers and the output register. A capacity write also empties the
    // buffer, which the datapath handles directly.
    brb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    brb_dp #(
        .STORE_BYTES  (STORE_BYTES),
        .MAX_TRANSFER (MAX_TRANSFER)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cap           (r_cap_eff),
        .i_cfg_clear     (cfg_wr),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_opcode        (i_opcode),
        .i_length        (i_length),
        .i_write_data    (i_write_data),
        .i_element_index (i_element_index),
        .i_out_stall     (i_stall),
        .o_out_valid     (o_valid),
        .o_status        (o_status),
        .o_read_data     (o_read_data),
        .o_fill_level    (o_fill_level)
    );

endmodule
`default_nettype wire
